// ----- hdl/lcn_pkg.sv -----
// ----------------------------------------------------------------------------
// lcn_pkg: shared types and constants of the command token parser
// Transaction payload structs and the character codes that the scanner uses.
// ----------------------------------------------------------------------------
package lcn_pkg;

    // Input transaction: one byte of the line, or an end-of-line marker.
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_line;
    } t_in_item;

    // Result transaction: one per line.
    typedef struct packed {
        logic               found;
        logic [1:0]         kind;
        logic signed [15:0] primary_value;
        logic signed [15:0] secondary_value;
    } t_out_item;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Command letter codes.
    localparam logic [2:0] LTR_S    = 3'd0;
    localparam logic [2:0] LTR_V    = 3'd1;
    localparam logic [2:0] LTR_P    = 3'd2;
    localparam logic [2:0] LTR_L    = 3'd3;
    localparam logic [2:0] LTR_R    = 3'd4;
    localparam logic [2:0] LTR_NONE = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_TURN = 2'd3;

    // Bit width of the largest magnitude that a token may carry.
    localparam int MAG_WIDTH = 15;

endpackage

// ----- hdl/letter_colon_number_command_parser.sv -----
// ----------------------------------------------------------------------------
// letter_colon_number_command_parser: command token scanner for text lines
// Finds the first "letter : number" token of a line and reports it per line.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_data) carries one
//   transaction per character of a line; a transaction with end_of_line set
//   closes the line. Each closing transaction yields exactly one result
//   transaction on the output channel (o_out_valid / i_out_ready / o_out_data)
//   telling whether a token was found, its kind and its values. Character
//   transactions yield no result.
//   o_out_valid rises once the end-of-line transaction has moved on from the
//   input register, where it is staged first, into the output register.
//   One transaction is accepted every cycle unless an end-of-line transaction
//   waits in the input register; the scanner state is updated by a single pass
//   between the input register and the state/result registers as it moves on.
//   When the receiver stalls, the result stays in the output register while
//   character transactions keep flowing; a second end-of-line transaction
//   waits in the input register, holding o_in_ready low, until the output
//   register frees up.
//   Reset (i_rst_n low, synchronous) empties both registers and starts a
//   fresh line.
// ----------------------------------------------------------------------------
module letter_colon_number_command_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lcn_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lcn_pkg::t_out_item o_out_data
);

    // Scan phases.
    localparam logic [2:0] PH_SEEK   = 3'd0;
    localparam logic [2:0] PH_LETTER = 3'd1;
    localparam logic [2:0] PH_COLON  = 3'd2;
    localparam logic [2:0] PH_SIGN   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    localparam int MW = lcn_pkg::MAG_WIDTH;

    // Input register.
    logic              r_in_valid;
    lcn_pkg::t_in_item r_in;

    // Scanner state.
    logic [2:0]    r_phase, n_phase;
    logic          r_prev_letter, n_prev_letter;
    logic [2:0]    r_pending, n_pending;
    logic          r_neg, n_neg;
    logic [MW-1:0] r_mag, n_mag;
    logic          r_fin, n_fin;
    logic          r_held_found, n_held_found;
    logic [1:0]    r_held_kind, n_held_kind;
    logic [15:0]   r_held_value, n_held_value;

    // Output register.
    logic               r_out_valid;
    lcn_pkg::t_out_item r_out;
    lcn_pkg::t_out_item n_out;

    logic          w_out_free;
    logic          w_advance;
    logic [7:0]    w_ch;
    logic          w_is_letter;
    logic          w_is_digit;
    logic          w_is_blank;
    logic [2:0]    w_code;
    logic [MW+3:0] w_mag_next;
    logic [15:0]   w_tok_value;
    logic [1:0]    w_tok_kind;
    logic          w_retry;
    logic          w_accept;

    // Map a character to its command letter code, either case.
    function automatic logic [2:0] letter_code(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= lcn_pkg::CH_LO_A && c <= lcn_pkg::CH_LO_Z) begin
            u = c - lcn_pkg::CASE_BIT;
        end
        unique case (u)
            lcn_pkg::CH_UP_S: letter_code = lcn_pkg::LTR_S;
            lcn_pkg::CH_UP_V: letter_code = lcn_pkg::LTR_V;
            lcn_pkg::CH_UP_P: letter_code = lcn_pkg::LTR_P;
            lcn_pkg::CH_UP_L: letter_code = lcn_pkg::LTR_L;
            lcn_pkg::CH_UP_R: letter_code = lcn_pkg::LTR_R;
            default:          letter_code = lcn_pkg::LTR_NONE;
        endcase
    endfunction

    // Handshake: the staged transaction moves on unless it closes a line while
    // the output register is still occupied.
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!r_in.end_of_line || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    // Character classes of the staged byte.
    assign w_ch        = r_in.character;
    assign w_is_letter = (w_ch >= lcn_pkg::CH_UP_A && w_ch <= lcn_pkg::CH_UP_Z) ||
                         (w_ch >= lcn_pkg::CH_LO_A && w_ch <= lcn_pkg::CH_LO_Z);
    assign w_is_digit  = w_ch >= lcn_pkg::CH_ZERO && w_ch <= lcn_pkg::CH_NINE;
    assign w_is_blank  = w_ch == lcn_pkg::CH_SPACE || w_ch == lcn_pkg::CH_TAB;
    assign w_code      = letter_code(w_ch);

    // Decimal accumulation: magnitude * 10 + digit, as two shifts and adds.
    assign w_mag_next = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) +
                        {{(MW){1'b0}}, w_ch[3:0]};

    // Signed value and kind of the token in progress.
    assign w_tok_value = r_neg ? (16'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
    assign w_tok_kind  = (r_pending >= lcn_pkg::LTR_L) ? lcn_pkg::KIND_TURN
                                                        : r_pending[1:0];

    // Next scanner state and the result of a closing transaction.
    always_comb begin
        logic       tok_found;
        logic [1:0] tok_kind;
        logic [15:0] tok_value;
        n_phase       = r_phase;
        n_prev_letter = r_prev_letter;
        n_pending     = r_pending;
        n_neg         = r_neg;
        n_mag         = r_mag;
        n_fin         = r_fin;
        n_held_found  = r_held_found;
        n_held_kind   = r_held_kind;
        n_held_value  = r_held_value;
        n_out         = '0;
        w_retry       = 1'b0;
        w_accept      = 1'b0;
        tok_found     = 1'b0;
        tok_kind      = 2'd0;
        tok_value     = 16'd0;

        if (!r_in.end_of_line) begin
            if (!r_fin) begin
                unique case (r_phase)
                    PH_LETTER: begin
                        if (w_ch == lcn_pkg::CH_COLON) begin
                            n_phase = PH_COLON;
                        end else if (!w_is_blank) begin
                            w_retry = 1'b1;
                        end
                    end
                    PH_COLON: begin
                        if (w_ch == lcn_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end else if (w_ch == lcn_pkg::CH_PLUS) begin
                            n_phase = PH_SIGN;
                        end else if (w_is_digit) begin
                            n_mag   = {{(MW-4){1'b0}}, w_ch[3:0]};
                            n_phase = PH_DIGITS;
                        end else if (!w_is_blank) begin
                            w_retry = 1'b1;
                        end
                    end
                    PH_SIGN: begin
                        if (w_is_digit) begin
                            n_mag   = {{(MW-4){1'b0}}, w_ch[3:0]};
                            n_phase = PH_DIGITS;
                        end else begin
                            w_retry = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_is_digit) begin
                            // Overflow past the 15-bit limit fails the attempt.
                            if (w_mag_next[MW+3:MW] != 4'd0) begin
                                w_retry = 1'b1;
                            end else begin
                                n_mag = w_mag_next[MW-1:0];
                            end
                        end else begin
                            w_accept = 1'b1;
                        end
                    end
                    default: begin
                        w_retry = 1'b1;
                    end
                endcase

                if (w_accept) begin
                    n_held_found = 1'b1;
                    n_held_kind  = w_tok_kind;
                    n_held_value = w_tok_value;
                    n_fin        = 1'b1;
                end else begin
                    // A failed attempt rescans the breaking byte as a start.
                    if (w_retry) begin
                        n_phase = PH_SEEK;
                        n_neg   = 1'b0;
                        n_mag   = '0;
                        if (w_ch == lcn_pkg::CH_NUL) begin
                            n_fin = 1'b1;
                        end else if (!r_prev_letter && w_code != lcn_pkg::LTR_NONE) begin
                            n_pending = w_code;
                            n_phase   = PH_LETTER;
                        end
                    end
                    n_prev_letter = w_is_letter;
                end
            end
        end else begin
            // End of line: a digit run still open is accepted here.
            if (r_held_found) begin
                tok_found = 1'b1;
                tok_kind  = r_held_kind;
                tok_value = r_held_value;
            end else if (!r_fin && r_phase == PH_DIGITS) begin
                tok_found = 1'b1;
                tok_kind  = w_tok_kind;
                tok_value = w_tok_value;
            end

            if (tok_found) begin
                n_out.found = 1'b1;
                n_out.kind  = tok_kind;
                if (tok_kind == lcn_pkg::KIND_TURN) begin
                    n_out.primary_value   = (r_pending == lcn_pkg::LTR_L) ? -16'sd1 : 16'sd1;
                    n_out.secondary_value = tok_value;
                end else begin
                    n_out.primary_value   = tok_value;
                    n_out.secondary_value = 16'sd0;
                end
            end

            // Start a fresh line.
            n_phase       = PH_SEEK;
            n_prev_letter = 1'b0;
            n_pending     = lcn_pkg::LTR_S;
            n_neg         = 1'b0;
            n_mag         = '0;
            n_fin         = 1'b0;
            n_held_found  = 1'b0;
            n_held_kind   = 2'd0;
            n_held_value  = 16'd0;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SEEK;
            r_prev_letter <= 1'b0;
            r_pending     <= lcn_pkg::LTR_S;
            r_neg         <= 1'b0;
            r_mag         <= '0;
            r_fin         <= 1'b0;
            r_held_found  <= 1'b0;
            r_held_kind   <= 2'd0;
            r_held_value  <= 16'd0;
        end else if (w_advance) begin
            r_phase       <= n_phase;
            r_prev_letter <= n_prev_letter;
            r_pending     <= n_pending;
            r_neg         <= n_neg;
            r_mag         <= n_mag;
            r_fin         <= n_fin;
            r_held_found  <= n_held_found;
            r_held_kind   <= n_held_kind;
            r_held_value  <= n_held_value;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && r_in.end_of_line;
        end
        if (w_out_free && w_advance && r_in.end_of_line) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A held token always means the line is finished.
    a_held_implies_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_found |-> r_fin)
        else $error("held token without finished line");

    // Seeking state carries no partial number.
    a_seek_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEEK) |-> (r_mag == '0 && !r_neg))
        else $error("partial number left while seeking");

    // A closing transaction that moves on shows up as a result next cycle.
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.end_of_line) |=> o_out_valid)
        else $error("end of line produced no result");

    // A line without a token reports all zeros.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.kind == 2'd0 && o_out_data.primary_value == 16'sd0 &&
         o_out_data.secondary_value == 16'sd0))
        else $error("empty line result not zero");

    // A turn carries a direction of one step.
    a_turn_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found && o_out_data.kind == lcn_pkg::KIND_TURN) |->
        (o_out_data.primary_value == 16'sd1 || o_out_data.primary_value == -16'sd1))
        else $error("turn direction out of range");

endmodule
